// File: hw/rtl/bf_pkg.sv
// shared types and constants of the 3x3 box filter
package bf_pkg;

	// sample format, signed q8.8
	localparam int SAMPLE_W = 16;

	// line buffer depth default
	localparam int MAX_COLS_DEF = 1024;

	// register widths
	localparam int ROWS_W = 16;
	localparam int COLS_W = 11;

	// row position runs up to rows + 1 during the drain phase
	localparam int ROW_W = ROWS_W + 1;

	// mean datapath widths
	localparam int RSUM_W = SAMPLE_W + 2;
	localparam int SUM_W = SAMPLE_W + 4;
	localparam int MAG_W = SAMPLE_W + 3;
	localparam int QUO_W = SAMPLE_W;

	// divide by 9 as multiply by a rounded-up reciprocal, exact for magnitudes below 2**MAG_W
	localparam int DIV_SHIFT = MAG_W + 3;
	localparam int DIVM_W = MAG_W;
	localparam logic [DIVM_W-1:0] DIV_MUL = DIVM_W'(((1 << DIV_SHIFT) + 8) / 9);
	localparam int PROD_W = MAG_W + DIVM_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// per-item control that travels beside the window data
	typedef struct packed {
		logic valid;
		logic border;
		logic last;
	} tag_t;

endpackage

// File: hw/rtl/box_filter_3x3_stencil.sv
// top level of the 3x3 mean stencil with line buffers and a window of cells
// throughput: one input transfer per clock unless stalled, fed by a single combined line ram
// an accepted transfer passes s1, window, row sums, magnitude, product and output register;
// every stage holds while the output register waits on m_axis_tready
// results lag the grid by one row plus one sample; cols+1 drain items end a frame
// reset: rows = 3, cols = 1024 (clamped to MAX_COLS), counters and window zero
// line buffer contents are not cleared by reset and need no clearing pass
module box_filter_3x3_stencil import bf_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// input stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
	input  logic [0:0]          s_axis_tuser,  // [0] drain
	// output stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [SAMPLE_W-1:0] m_axis_tdata,  // [15:0] value
	output logic                m_axis_tlast
);

	localparam int AW = $clog2(MAX_COLS);
	localparam int NCW = $clog2(MAX_COLS + 1);
	localparam int TOTW = ROWS_W + NCW;
	localparam int CMPW = (NCW > COLS_W) ? NCW : COLS_W;
	localparam int NC_RST = (1024 > MAX_COLS) ? MAX_COLS : 1024;
	localparam int WORD_W = 2 * SAMPLE_W;

	// register index, taken from the word address
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// ---------------- configuration ----------------
	logic cfg_wr;
	logic [ROWS_W-1:0] rows_q, nr_q, nr_new;
	logic [COLS_W-1:0] cols_q;
	logic [NCW-1:0] nc_q, nc_new;
	logic [TOTW-1:0] total_q;
	logic [CMPW-1:0] cols_wide;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows_q) : 32'(cols_q);

	// effective sizes: zero acts as one, cols clamp at the line buffer depth
	always_comb begin
		nr_new = (pwdata[ROWS_W-1:0] == '0) ? ROWS_W'(1) : pwdata[ROWS_W-1:0];
		cols_wide = CMPW'(pwdata[COLS_W-1:0]);
		if (cols_wide == '0) begin
			nc_new = NCW'(1);
		end else if (cols_wide > CMPW'(MAX_COLS)) begin
			nc_new = NCW'(MAX_COLS);
		end else begin
			nc_new = NCW'(cols_wide);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_W'(3);
			cols_q <= COLS_W'(1024);
			nr_q <= ROWS_W'(3);
			nc_q <= NCW'(NC_RST);
			total_q <= TOTW'(3 * NC_RST);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROWS) begin
				rows_q <= pwdata[ROWS_W-1:0];
				nr_q <= nr_new;
				total_q <= TOTW'(nr_new) * TOTW'(nc_q);
			end else if (paddr[2] == REG_COLS) begin
				cols_q <= pwdata[COLS_W-1:0];
				nc_q <= nc_new;
				total_q <= TOTW'(nr_q) * TOTW'(nc_new);
			end
		end
	end

	// ---------------- flow control ----------------
	// every stage moves together whenever the output register is free or leaving
	logic en, in_xfer;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign in_xfer = s_axis_tvalid && en;

	// ---------------- position tracking, input stage ----------------
	logic [AW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [TOTW-1:0] out_cnt_q;
	logic col_wrap, emit, border, last_hit;
	sample_t s_in;

	always_comb begin
		col_wrap = (NCW'(col_q) + NCW'(1)) == nc_q;
		// column zero finishes the last column two rows up, others the column to the left
		emit = (col_q == '0) ? (row_q >= ROW_W'(2)) : (row_q >= ROW_W'(1));
		border = (col_q == '0) || (col_q == AW'(1)) || (row_q == ROW_W'(1)) ||
			(row_q >= ROW_W'(nr_q));
		last_hit = (out_cnt_q + TOTW'(1)) >= total_q;
		// drains and items past the last grid row count as zero samples
		s_in = ((row_q < ROW_W'(nr_q)) && !s_axis_tuser[0]) ? sample_t'(s_axis_tdata) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			out_cnt_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
			out_cnt_q <= '0;
		end else if (in_xfer) begin
			if (emit && last_hit) begin
				// frame ends with the transfer that yields its final result
				col_q <= '0;
				row_q <= '0;
				out_cnt_q <= '0;
			end else begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
				if (emit) begin
					out_cnt_q <= out_cnt_q + TOTW'(1);
				end
			end
		end
	end

	// ---------------- line buffers ----------------
	// one word per column: upper half is the row just above, lower half two rows up
	logic v_s1, emit_s1, border_s1, last_s1, fwd_s1;
	logic [AW-1:0] c_s1;
	sample_t s_s1;
	logic [WORD_W-1:0] ram_rdata, word, fwd_word_q, wr_word;
	logic ram_we;

	assign ram_we = en && v_s1;
	assign word = fwd_s1 ? fwd_word_q : ram_rdata;
	assign wr_word = {s_s1, word[WORD_W-1:SAMPLE_W]};

	bf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_COLS)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(c_s1),
		.wdata(wr_word),
		.re   (in_xfer),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= col_q;
			s_s1 <= s_in;
			emit_s1 <= emit;
			border_s1 <= border;
			last_s1 <= emit && last_hit;
			// a one-column grid reads the entry that is written at the same edge
			fwd_s1 <= v_s1 && (c_s1 == col_q);
		end
		if (ram_we) begin
			fwd_word_q <= wr_word;
		end
	end

	// ---------------- window: three rows of three cells ----------------
	sample_t win [9];
	sample_t col_in [3];
	logic win_shift;

	assign col_in[0] = sample_t'(word[SAMPLE_W-1:0]);
	assign col_in[1] = sample_t'(word[WORD_W-1:SAMPLE_W]);
	assign col_in[2] = s_s1;
	assign win_shift = en && v_s1;

	for (genvar k = 0; k < 9; k++) begin : g_cell
		if ((k % 3) == 2) begin : g_edge
			// rightmost cell takes the fresh column
			bf_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.clr   (cfg_wr),
				.shift (win_shift),
				.din   (col_in[k / 3]),
				.dout  (win[k])
			);
		end else begin : g_inner
			bf_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.clr   (cfg_wr),
				.shift (win_shift),
				.din   (win[k + 1]),
				.dout  (win[k])
			);
		end
	end

	// ---------------- control beside the window ----------------
	tag_t tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2.valid <= v_s1 && emit_s1;
			tag_s2.border <= border_s1;
			tag_s2.last <= last_s1;
		end
	end

	// ---------------- mean and output register ----------------
	sample_t out_value;

	bf_mean u_mean (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.tag_i (tag_s2),
		.win   (win),
		.valid (m_axis_tvalid),
		.value (out_value),
		.last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_value;

endmodule

// File: hw/rtl/bf_ram.sv
// generic single-write, single-read ram with registered read data
module bf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/bf_cell.sv
// one window cell: holds a sample and hands it to its left neighbor on shift
module bf_cell import bf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    clr,
	input  logic    shift,
	input  sample_t din,
	output sample_t dout
);

	sample_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (clr) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

endmodule

// File: hw/rtl/bf_mean.sv
// window sum, divide by nine and border select, ending in the output register
module bf_mean import bf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  tag_t    tag_i,
	input  sample_t win [9],
	output logic    valid,
	output sample_t value,
	output logic    last
);

	tag_t tag_s3, tag_s4, tag_s5;
	logic signed [RSUM_W-1:0] rsum_s3 [3];
	sample_t ctr_s3, ctr_s4, ctr_s5;
	logic [MAG_W-1:0] mag_s4;
	logic neg_s4, neg_s5;
	logic [PROD_W-1:0] prod_s5;
	logic out_valid_q, last_q;
	sample_t value_q;

	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0] abs_sum;
	logic [QUO_W-1:0] quo;
	sample_t mean;

	always_comb begin
		sum = SUM_W'(rsum_s3[0]) + SUM_W'(rsum_s3[1]) + SUM_W'(rsum_s3[2]);
		abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		quo = prod_s5[DIV_SHIFT +: QUO_W];
		// truncation toward zero: divide the magnitude, then restore the sign
		mean = neg_s5 ? sample_t'(-quo) : sample_t'(quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			out_valid_q <= 1'b0;
			last_q <= 1'b0;
		end else if (en) begin
			tag_s3 <= tag_i;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			out_valid_q <= tag_s5.valid;
			last_q <= tag_s5.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rsum_s3[i] <= RSUM_W'(win[3*i]) + RSUM_W'(win[3*i+1]) + RSUM_W'(win[3*i+2]);
			end
			ctr_s3 <= win[4];
			mag_s4 <= abs_sum[MAG_W-1:0];
			neg_s4 <= sum[SUM_W-1];
			ctr_s4 <= ctr_s3;
			prod_s5 <= mag_s4 * DIV_MUL;
			neg_s5 <= neg_s4;
			ctr_s5 <= ctr_s4;
			value_q <= tag_s5.border ? ctr_s5 : mean;
		end
	end

	assign valid = out_valid_q;
	assign value = value_q;
	assign last = last_q;

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the 3x3 box filter: directed table, random frames, scoreboard
module tb_top;
	import bf_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int LINE_DEPTH     = MAX_COLS_DEF;
	// register indexes, byte address is 4 * index
	localparam int REG_ROWS       = 0;
	localparam int REG_COLS       = 1;
	// give the pipeline some margin before touching registers
	localparam int SETTLE_CYCLES  = 16;
	localparam int LONG_HOLD      = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int MAX_REPORTS    = 10;

	typedef enum logic [1:0] {ROW_ITEM, ROW_SET_ROWS, ROW_SET_COLS} row_kind_e;
	typedef enum logic [1:0] {STYLE_MIXED, STYLE_TOP, STYLE_BOTTOM} frame_style_e;
	typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_HEAVY} stall_mode_e;

	// one filtered value as it leaves the block
	typedef struct packed {
		sample_t value;
		logic    is_last;
	} stencil_out_t;

	// one line of the directed table: a register write or an input transfer
	typedef struct {
		row_kind_e   kind;
		logic [31:0] data;
		bit          drain;
		bit          typed;
		sample_t     exp_value;
		bit          exp_last;
	} dir_row_t;

	// clock, reset and block ports; those driven here are known from time zero
	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [2:0]          paddr         = '0;
	logic [31:0]         pwdata        = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata  = '0;  // [15:0] sample
	logic [0:0]          s_axis_tuser  = '0;  // [0] drain
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;        // [15:0] value
	logic                m_axis_tlast;

	// mirror of the filter state, line buffers start at zero since stale entries never matter
	sample_t             line_up [LINE_DEPTH];
	sample_t             line_mid[LINE_DEPTH];
	int                  win[3][3];
	int unsigned         pos_row;
	int unsigned         pos_col;
	int unsigned         out_seen;
	logic [ROWS_W-1:0]   rows_q;
	logic [COLS_W-1:0]   cols_q;

	// filtered values still owed by the block, oldest first
	stencil_out_t        filtered_due[$];
	dir_row_t            dir_rows[$];

	int                  mismatch_count = 0;
	int                  quiet_cycles   = 0;
	int                  burst_left     = 0;
	int                  rand_items     = 0;
	bit                  hold_ask       = 1'b0;
	int                  hold_left      = 0;
	int                  seg_left       = 0;
	stall_mode_e         seg_mode       = RX_FREE;
	stencil_out_t        got_due;

	box_filter_3x3_stencil #(
		.MAX_COLS(LINE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------- predictor ----------------

	// zero rows acts as one
	function automatic int unsigned eff_rows();
		return (rows_q == 0) ? 1 : rows_q;
	endfunction

	// zero cols acts as one, oversized cols clamps to the line depth
	function automatic int unsigned eff_cols();
		if (cols_q == 0)
			return 1;
		if (cols_q > LINE_DEPTH)
			return LINE_DEPTH;
		return cols_q;
	endfunction

	// position counters, frame count and window go back to zero, line buffers keep their data
	task automatic restart_frame();
		int i;
		int j;
		pos_row = 0;
		pos_col = 0;
		out_seen = 0;
		for (i = 0; i < 3; i++)
			for (j = 0; j < 3; j++)
				win[i][j] = 0;
	endtask

	// advance the mirror by one input transfer, emit says whether a value comes out of it
	task automatic stencil_step(input sample_t smp, input bit drn, output bit emit,
			output stencil_out_t res);
		int unsigned nr;
		int unsigned nc;
		int unsigned c;
		int unsigned r;
		int unsigned cc;
		int          s;
		int          val;
		int          sum;
		int          i;
		int          j;
		nr = eff_rows();
		nc = eff_cols();
		c = (pos_col >= nc) ? 0 : pos_col;
		// drain in the sample phase counts as zero, anything in the drain phase is ignored
		s = 0;
		if (pos_row < nr && !drn)
			s = smp;
		emit = 1'b0;
		val = 0;
		res = '0;
		// start of a row finishes the last column two rows up
		if (c == 0 && pos_row >= 2) begin
			val = line_up[nc - 1];
			emit = 1'b1;
		end
		for (i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = line_up[c];
		win[1][2] = line_mid[c];
		win[2][2] = s;
		if (c >= 1 && pos_row >= 1) begin
			r = pos_row - 1;
			cc = c - 1;
			if (r == 0 || r + 1 >= nr || cc == 0 || cc + 1 >= nc) begin
				val = win[1][1];
			end else begin
				sum = 0;
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						sum += win[i][j];
				// int division truncates toward zero
				val = sum / 9;
			end
			emit = 1'b1;
		end
		line_up[c] = line_mid[c];
		line_mid[c] = SAMPLE_W'(s);
		pos_col = c + 1;
		if (pos_col >= nc) begin
			pos_col = 0;
			pos_row++;
		end
		if (emit) begin
			res.value = SAMPLE_W'(val);
			// the value marked last also closes the frame
			if (out_seen + 1 >= nr * nc) begin
				res.is_last = 1'b1;
				pos_row = 0;
				pos_col = 0;
				out_seen = 0;
			end else begin
				res.is_last = 1'b0;
				out_seen++;
			end
		end
	endtask

	// ---------------- bus activity ----------------

	// apb write, setup then access, register lands at the edge with penable and pready high
	task automatic write_reg(input int idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_ROWS)
			rows_q = val[ROWS_W-1:0];
		else
			cols_q = val[COLS_W-1:0];
		restart_frame();
		// leave the bus idle before the next bus access
		@(posedge clk);
	endtask

	// stop offering, wait for every owed value, then let the pipeline settle
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (filtered_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// offer one transfer, with bursts and gaps; a typed row overrides the predicted value
	task automatic send_item(input sample_t smp, input bit drn, input bit typed,
			input stencil_out_t typed_res);
		int           gap;
		bit           emit;
		stencil_out_t res;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= drn;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// transfer accepted at this edge
		stencil_step(smp, drn, emit, res);
		if (typed)
			filtered_due.push_back(typed_res);
		else if (emit)
			filtered_due.push_back(res);
	endtask

	function automatic sample_t rand_sample(input frame_style_e style);
		if (style == STYLE_TOP)
			return 16'h7FFF;
		if (style == STYLE_BOTTOM)
			return 16'h8000;
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_W'($urandom_range(0, 31) - 16);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// one register setting followed by whole frames, optionally the last one cut short
	task automatic run_phase(input logic [31:0] rows_v, input logic [31:0] cols_v,
			input int frames, input bit cut, input int cut_cap, input int hold_at);
		int unsigned  nr;
		int unsigned  nc;
		int           len;
		int           f;
		int           k;
		frame_style_e style;
		bit           drn;
		quiesce();
		// junk above the register width must be dropped
		if ($urandom_range(0, 3) == 0)
			rows_v = rows_v | ($urandom << ROWS_W);
		if ($urandom_range(0, 3) == 0)
			cols_v = cols_v | ($urandom << COLS_W);
		write_reg(REG_ROWS, rows_v);
		write_reg(REG_COLS, cols_v);
		nr = eff_rows();
		nc = eff_cols();
		for (f = 0; f < frames; f++) begin
			len = nr * nc + nc + 1;
			// broken frame: stop early, the next register write restarts the block
			if (cut && f == frames - 1)
				len = $urandom_range(1, (len - 1 < cut_cap) ? len - 1 : cut_cap);
			case ($urandom_range(0, 9))
				0: style = STYLE_TOP;
				1: style = STYLE_BOTTOM;
				default: style = STYLE_MIXED;
			endcase
			for (k = 0; k < len; k++) begin
				if (k == hold_at)
					hold_ask = 1'b1;
				// sample phase: mostly samples, a few drains; drain phase: mostly drains
				if (k < nr * nc)
					drn = ($urandom_range(0, 9) == 0);
				else
					drn = ($urandom_range(0, 4) != 0);
				send_item(rand_sample(style), drn, 1'b0, '0);
				rand_items++;
			end
		end
	endtask

	function automatic dir_row_t row(input row_kind_e kind, input logic [31:0] data,
			input bit drain, input bit typed, input sample_t exp_value, input bit exp_last);
		dir_row_t t;
		t.kind = kind;
		t.data = data;
		t.drain = drain;
		t.typed = typed;
		t.exp_value = exp_value;
		t.exp_last = exp_last;
		return t;
	endfunction

	// ---------------- receiver, scoreboard, watchdog ----------------

	// receiver stall pattern in segments, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_ask) begin
			hold_ask = 1'b0;
			hold_left = LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_mode = stall_mode_e'($urandom_range(0, 2));
				seg_left = $urandom_range(4, 120);
			end
			seg_left--;
			case (seg_mode)
				RX_FREE: m_axis_tready <= 1'b1;
				RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// every output transfer is matched against the oldest owed value
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (filtered_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected output transfer: value %h last %b",
						m_axis_tdata, m_axis_tlast);
			end else begin
				got_due = filtered_due.pop_front();
				if (m_axis_tdata !== got_due.value || m_axis_tlast !== got_due.is_last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected value %h last %b, got value %h last %b",
							got_due.value, got_due.is_last, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	// no transfer on either side for too long means the block is stuck
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("FAIL box_filter_3x3_stencil");
					$finish;
				end
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int           n;
		logic [31:0]  rows_v;
		logic [31:0]  cols_v;
		stencil_out_t typed_res;

		// 3x3 frame: extremes, a drain in the sample phase, a sample in the drain phase
		dir_rows.push_back(row(ROW_SET_ROWS, 32'd3, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_SET_COLS, 32'd3, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h7FFF, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h8000, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0005, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'hFFFF, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0064, 0, 1, 16'h7FFF, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0007, 0, 1, 16'h8000, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 0, 1, 16'h0005, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h5A5A, 1, 1, 16'hFFFF, 0));
		// center: sum 119, mean 13
		dir_rows.push_back(row(ROW_ITEM, 32'h0009, 0, 1, 16'h000D, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 1, 1, 16'h0007, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h1234, 0, 1, 16'h0000, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'hFFFF, 1, 1, 16'h0000, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 1, 1, 16'h0009, 1));
		// zero registers act as a 1x1 grid
		dir_rows.push_back(row(ROW_SET_ROWS, 32'd0, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_SET_COLS, 32'd0, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h8000, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 1, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h7FFF, 0, 1, 16'h8000, 1));
		// single row, junk above the register widths, all border
		dir_rows.push_back(row(ROW_SET_ROWS, 32'hFFFF_0001, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_SET_COLS, 32'h0000_F803, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h7FFF, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'hFFFF, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'hA5A5, 1, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h5A5A, 0, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 1, 0, '0, 0));
		dir_rows.push_back(row(ROW_ITEM, 32'h0000, 1, 0, '0, 0));

		// reset state of the mirror
		for (n = 0; n < LINE_DEPTH; n++) begin
			line_up[n] = '0;
			line_mid[n] = '0;
		end
		rows_q = ROWS_W'(3);
		cols_q = COLS_W'(1024);
		restart_frame();

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[n]) begin
			case (dir_rows[n].kind)
				ROW_SET_ROWS: begin
					quiesce();
					write_reg(REG_ROWS, dir_rows[n].data);
				end
				ROW_SET_COLS: begin
					quiesce();
					write_reg(REG_COLS, dir_rows[n].data);
				end
				default: begin
					typed_res.value = dir_rows[n].exp_value;
					typed_res.is_last = dir_rows[n].exp_last;
					send_item(dir_rows[n].data[SAMPLE_W-1:0], dir_rows[n].drain,
						dir_rows[n].typed, typed_res);
				end
			endcase
		end

		// a whole frame at the reset row count with a long receiver hold-off once values flow,
		// then oversized cols and the largest row count, both cut short
		run_phase(32'd3, 32'd64, 1, 1'b0, 0, 120);
		run_phase(32'd1, 32'd2047, 1, 1'b1, 150, -1);
		run_phase(32'd65535, 32'd2, 1, 1'b1, 150, -1);

		// small random grids, some narrow, some frames broken off
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			rows_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			cols_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			run_phase(rows_v, cols_v, $urandom_range(1, 3), ($urandom_range(0, 6) == 0),
				1 << 30, -1);
		end

		// drain everything owed and let the pipeline run empty
		quiesce();
		if (mismatch_count == 0 && filtered_due.size() == 0)
			$display("PASS box_filter_3x3_stencil");
		else
			$display("FAIL box_filter_3x3_stencil");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/bf_pkg.sv
hw/rtl/bf_ram.sv
hw/rtl/bf_cell.sv
hw/rtl/bf_mean.sv
hw/rtl/box_filter_3x3_stencil.sv
verif/tb_top.sv
